// ===== hdl/mexp_pkg.sv =====
package mexp_pkg;

   // field widths
   localparam int unsigned RES_WIDTH  = 30;
   localparam int unsigned EXP_WIDTH  = 64;
   localparam int unsigned REQ_WIDTH  = 96;
   localparam int unsigned RSP_WIDTH  = 32;

   // bit-serial multiplier step counter
   localparam int unsigned CNT_WIDTH  = $clog2(RES_WIDTH);

   localparam logic [RES_WIDTH-1:0] PRIME = RES_WIDTH'(998244353);
   localparam logic [RES_WIDTH-1:0] ONE   = RES_WIDTH'(1);

   // partial sum of one serial step is below three times the prime
   localparam logic [RES_WIDTH+1:0] PRIME_WIDE     = {2'b00, PRIME};
   localparam logic [RES_WIDTH+1:0] TWO_PRIME_WIDE = {1'b0, PRIME, 1'b0};

endpackage

// ===== hdl/modular_exponentiation.sv =====
// Base to a signed 64-bit exponent modulo 998244353, right-to-left square and multiply.
// Each exponent bit: a check state, one pass of two bit-serial modular multipliers
// (square and accumulate side by side) and an update once both are done.
// A new request is taken only in the idle state, after the last result is registered;
// reset clears control state only.
module modular_exponentiation (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [29:0] base_value, [93:30] exponent, [95:94] zero
   input  logic [mexp_pkg::REQ_WIDTH-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [29:0] power_result, [31:30] zero
   output logic [mexp_pkg::RSP_WIDTH-1:0] rsp_tdata
);
   import mexp_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_CHECK = 4'b0010,
      S_MUL   = 4'b0100,
      S_OUT   = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [RES_WIDTH-1:0] acc_ff, acc_in;
   logic [RES_WIDTH-1:0] base_ff, base_in;
   logic [EXP_WIDTH-2:0] exp_ff, exp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RES_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic                 req_xfer;
   logic                 mul_start;
   logic                 acc_done, sq_done;
   logic [RES_WIDTH-1:0] acc_prod, sq_prod;
   logic [RES_WIDTH-1:0] req_base;
   logic [EXP_WIDTH-1:0] req_exp;
   logic [RES_WIDTH-1:0] base_red;

   assign req_base = req_tdata[RES_WIDTH-1:0];
   assign req_exp  = req_tdata[RES_WIDTH+EXP_WIDTH-1:RES_WIDTH];
   assign base_red = (req_base >= PRIME) ? (req_base - PRIME) : req_base;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign mul_start  = (state_ff == S_CHECK) && (exp_ff != '0);

   mexp_modmul u_acc_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (acc_ff),
      .op_b    (base_ff),
      .done    (acc_done),
      .product (acc_prod)
   );

   mexp_modmul u_sq_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (base_ff),
      .op_b    (base_ff),
      .done    (sq_done),
      .product (sq_prod)
   );

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               base_in = base_red;
               // a negative exponent leaves the accumulator at zero and no bits to walk
               if (req_exp[EXP_WIDTH-1]) begin
                  acc_in = '0;
                  exp_in = '0;
               end else begin
                  acc_in = ONE;
                  exp_in = req_exp[EXP_WIDTH-2:0];
               end
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (exp_ff == '0) begin
               state_in = S_OUT;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (acc_done && sq_done) begin
               if (exp_ff[0]) begin
                  acc_in = acc_prod;
               end
               base_in  = sq_prod;
               exp_in   = {1'b0, exp_ff[EXP_WIDTH-2:1]};
               state_in = S_CHECK;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff      <= acc_in;
      base_ff     <= base_in;
      exp_ff      <= exp_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_WIDTH-RES_WIDTH){1'b0}}, rsp_data_ff};

endmodule

// ===== hdl/mexp_modmul.sv =====
module mexp_modmul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [mexp_pkg::RES_WIDTH-1:0] op_a,
   input  logic [mexp_pkg::RES_WIDTH-1:0] op_b,
   output logic                           done,
   output logic [mexp_pkg::RES_WIDTH-1:0] product
);
   import mexp_pkg::*;

   logic [RES_WIDTH-1:0] a_sh_ff, a_sh_in;
   logic [RES_WIDTH-1:0] b_ff, b_in;
   logic [RES_WIDTH-1:0] r_ff, r_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [RES_WIDTH+1:0] sum;
   logic [RES_WIDTH+1:0] reduced;

   // one multiplier bit per cycle, MSB first: r = 2r + a_i*b, then fold below the prime
   always_comb begin
      sum = {1'b0, r_ff, 1'b0} + ((a_sh_ff[RES_WIDTH-1]) ? {2'b00, b_ff} : '0);
      if (sum >= TWO_PRIME_WIDE) begin
         reduced = sum - TWO_PRIME_WIDE;
      end else if (sum >= PRIME_WIDE) begin
         reduced = sum - PRIME_WIDE;
      end else begin
         reduced = sum;
      end
   end

   always_comb begin
      a_sh_in = a_sh_ff;
      b_in    = b_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_sh_in = op_a;
         b_in    = op_b;
         r_in    = '0;
         cnt_in  = CNT_WIDTH'(RES_WIDTH - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         a_sh_in = {a_sh_ff[RES_WIDTH-2:0], 1'b0};
         r_in    = reduced[RES_WIDTH-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_sh_ff <= a_sh_in;
      b_ff    <= b_in;
      r_ff    <= r_in;
      cnt_ff  <= cnt_in;
   end

   assign done    = done_ff;
   assign product = r_ff;

endmodule

// ===== bench/modular_exponentiation_test.sv =====
module modular_exponentiation_test;

   import mexp_pkg::*;

   localparam longint unsigned MODULUS  = 64'(PRIME);
   localparam logic [29:0]     BASE_MAX = 30'h3FFF_FFFF;
   localparam logic [63:0]     EXP_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0]     EXP_MIN  = 64'h8000_0000_0000_0000;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_WIDTH-1:0] req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_WIDTH-1:0] rsp_tdata;

   logic [29:0] expected_powers[$];
   int unsigned fail_count    = 0;
   bit          idle_enable   = 1'b1;
   int unsigned gap_percent   = 20;
   int unsigned stall_percent = 20;
   int unsigned stall_left    = 0;

   modular_exponentiation dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // base to a signed exponent mod the prime, zero for negative exponents
   function automatic logic [29:0] predict_power(logic [29:0] base, logic [63:0] expo);
      longint unsigned acc;
      longint unsigned sq;
      longint unsigned e;
      if (expo[63])
         return '0;
      acc = 1;
      sq  = 64'(base) % MODULUS;
      e   = expo;
      while (e != 0) begin
         if (e[0])
            acc = (acc * sq) % MODULUS;
         sq = (sq * sq) % MODULUS;
         e  = e >> 1;
      end
      return acc[29:0];
   endfunction

   function automatic logic [29:0] random_base();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return 30'($urandom_range(0, int'(PRIME) - 1));
      if (pick < 70) begin
         case ($urandom_range(0, 2))
            0:       return '0;
            1:       return 30'd1;
            default: return PRIME - 30'd1;
         endcase
      end
      // at or above the modulus, reduced before use
      if (pick < 85)
         return 30'($urandom_range(int'(PRIME), int'(BASE_MAX)));
      return 30'($urandom);
   endfunction

   // mostly short exponents keep the run short; a few reach up to the full 63 bits
   function automatic logic [63:0] random_exponent();
      logic [63:0] raw;
      int unsigned pick;
      int unsigned bits;
      raw  = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 10)
         return raw | EXP_MIN;
      if (pick < 15)
         return '0;
      if (pick < 80)
         bits = $urandom_range(1, 12);
      else if (pick < 93)
         bits = $urandom_range(13, 32);
      else
         bits = $urandom_range(33, 63);
      raw = raw & ((64'd1 << bits) - 64'd1);
      raw[bits-1] = 1'b1;
      return raw;
   endfunction

   // called at a rising edge; returns at the edge of the transfer
   task automatic send_request(logic [29:0] base, logic [63:0] expo);
      if (idle_enable && $urandom_range(0, 99) < gap_percent) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, expo, base};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      expected_powers.push_back(predict_power(base, expo));
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 99) < stall_percent) begin
         stall_left <= $urandom_range(0, 12);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      logic [29:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_powers.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("result transfer with none expected: got %0d", rsp_tdata[29:0]);
         end else begin
            want = expected_powers.pop_front();
            if (rsp_tdata[29:0] !== want) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("power_result mismatch: expected %0d, got %0d",
                           want, rsp_tdata[29:0]);
            end
         end
      end
   end

   task automatic test_edge_operands();
      send_request(30'd0, 64'd1);
      send_request(30'd0, 64'd5);
      send_request(PRIME - 30'd1, 64'd1);
      send_request(PRIME, 64'd3);
      send_request(BASE_MAX, 64'd7);
      send_request(30'd2, 64'd62);
      send_request(30'd3, EXP_MAX);
      send_request(PRIME - 30'd1, EXP_MAX);
      send_request(30'd1, EXP_MAX);
      send_request(BASE_MAX, EXP_MAX);
      // Fermat: base to the prime minus one is one
      send_request(30'd2, 64'(PRIME) - 64'd1);
      send_request(30'd3, 64'd1 << 62);
   endtask

   task automatic test_zero_and_negative_exponents();
      send_request(30'd0, 64'd0);
      send_request(30'd12345, 64'd0);
      send_request(BASE_MAX, 64'd0);
      send_request(30'd5, -64'sd1);
      send_request(30'd5, EXP_MIN);
      send_request(30'd0, -64'sd1);
      send_request(BASE_MAX, -64'sd12345);
      send_request(PRIME - 30'd1, -64'sd2);
   endtask

   task automatic test_random_mixed(int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 100 == 0) begin
            case ($urandom_range(0, 3))
               0: begin gap_percent = 0;  stall_percent = 0;  end
               1: begin gap_percent = 10; stall_percent = 5;  end
               2: begin gap_percent = 40; stall_percent = 30; end
               default: begin gap_percent = 70; stall_percent = 60; end
            endcase
         end
         send_request(random_base(), random_exponent());
      end
   endtask

   task automatic test_back_to_back(int unsigned count);
      idle_enable = 1'b0;
      for (int unsigned i = 0; i < count; i++)
         send_request(random_base(), random_exponent());
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_edge_operands();
      test_zero_and_negative_exponents();
      test_random_mixed(1300);
      test_back_to_back(330);
      req_tvalid <= 1'b0;
      while (expected_powers.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0 && expected_powers.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #60_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
